// File: rtl/core/rlol_pkg.sv
`default_nettype none

package rlol_pkg;

  // ring geometry
  localparam int unsigned Depth   = 16;
  localparam int unsigned PtrW    = (Depth > 1) ? $clog2(Depth) : 1;

  // field widths
  localparam int unsigned HandleW = 32;
  localparam int unsigned LenW    = 20;
  localparam int unsigned OffW    = 24;
  localparam int unsigned SlotW   = 4;

  // opcodes
  localparam logic OpAdd  = 1'b0;
  localparam logic OpFind = 1'b1;

  typedef logic [PtrW-1:0] ptr_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the new item
    logic add;    // write slot and move pointers
    logic walk;   // process one slot of a find
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;  // hit found or last slot processed
  } dp_sts_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StAdd  = 4'b0010,
    StWalk = 4'b0100,
    StResp = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/rlol_ctrl.sv
`default_nettype none

module rlol_ctrl
  import rlol_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire logic    opcode_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o,
  output logic         busy_o,
  output logic         done_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = (opcode_i == OpAdd) ? StAdd : StWalk;
        end
      end
      StAdd:  state_d = StResp;
      StWalk: begin
        if (sts_i.walk_done) begin
          state_d = StResp;
        end
      end
      StResp: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o.load = (state_q == StIdle) && start_i;
    cmd_o.add  = (state_q == StAdd);
    cmd_o.walk = (state_q == StWalk);
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StResp);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_walk_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.walk && sts_i.walk_done) |=> done_o)
    else $error("finished walk did not deliver a result");

endmodule

`default_nettype wire

// File: rtl/core/rlol_datapath.sv
`default_nettype none

module rlol_datapath
  import rlol_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  input  wire logic [HandleW-1:0] record_handle_i,
  input  wire logic [LenW-1:0]    record_length_i,
  input  wire logic [OffW-1:0]    char_offset_i,
  output dp_sts_t                 sts_o,
  output logic                    found_o,
  output logic [SlotW-1:0]        slot_index_o,
  output logic [HandleW-1:0]      found_handle_o,
  output logic [LenW-1:0]         found_length_o,
  output logic [LenW-1:0]         byte_in_record_o,
  output logic                    ring_full_o
);

  // slot storage, valid bits stand in for the cleared reset contents
  logic [HandleW-1:0] handle_mem_q [Depth];
  logic [LenW-1:0]    length_mem_q [Depth];
  logic [Depth-1:0]   valid_q;

  ptr_t wp_q, rp_q, step_q;
  ptr_t wp_next, rp_next;
  logic full_q;

  logic [HandleW-1:0] in_handle_q;
  logic [LenW-1:0]    in_length_q;
  logic [OffW-1:0]    offset_q;
  logic [OffW-1:0]    sum_q;

  logic               found_q;
  logic [SlotW-1:0]   slot_q;
  logic [HandleW-1:0] fhandle_q;
  logic [LenW-1:0]    flength_q;
  logic [LenW-1:0]    byte_q;

  // walk address
  logic [PtrW:0]      idx_wide;
  ptr_t               idx;
  logic [HandleW-1:0] rd_handle;
  logic [LenW-1:0]    rd_length;
  logic [OffW:0]      sum_wide;
  logic [OffW-1:0]    sum_sat;
  logic [OffW-1:0]    byte_wide;
  logic               hit;
  logic               last_step;

  assign wp_next = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + ptr_t'(1);
  assign rp_next = (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + ptr_t'(1);

  always_comb begin
    idx_wide = {1'b0, rp_q} + {1'b0, step_q};
    if (idx_wide >= (PtrW + 1)'(Depth)) begin
      idx = PtrW'(idx_wide - (PtrW + 1)'(Depth));
    end else begin
      idx = idx_wide[PtrW-1:0];
    end
    rd_handle = valid_q[idx] ? handle_mem_q[idx] : '0;
    rd_length = valid_q[idx] ? length_mem_q[idx] : '0;
    sum_wide  = {1'b0, sum_q} + (OffW + 1)'(rd_length);
    sum_sat   = sum_wide[OffW] ? '1 : sum_wide[OffW-1:0];
    hit       = sum_sat > offset_q;
    byte_wide = offset_q - sum_q;
    last_step = (step_q == PtrW'(Depth - 1));
  end

  assign sts_o.walk_done = hit || last_step;

  // control state: pointers, full flag, valid bits, walk counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      full_q  <= 1'b0;
      valid_q <= '0;
      step_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
      end else if (cmd_i.walk) begin
        step_q <= last_step ? step_q : step_q + ptr_t'(1);
      end
      if (cmd_i.add) begin
        valid_q[wp_q] <= 1'b1;
        wp_q          <= wp_next;
        if (full_q) begin
          rp_q   <= rp_next;
          full_q <= (wp_next == rp_next);
        end else begin
          full_q <= (wp_next == rp_q);
        end
      end
    end
  end

  // payload: slot contents, captured item, running sum, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      handle_mem_q[wp_q] <= in_handle_q;
      length_mem_q[wp_q] <= in_length_q;
    end
    if (cmd_i.load) begin
      in_handle_q <= record_handle_i;
      in_length_q <= record_length_i;
      offset_q    <= char_offset_i;
      sum_q       <= '0;
      found_q     <= 1'b0;
      slot_q      <= '0;
      fhandle_q   <= '0;
      flength_q   <= '0;
      byte_q      <= '0;
    end else if (cmd_i.walk) begin
      sum_q <= sum_sat;
      if (hit) begin
        found_q   <= 1'b1;
        slot_q    <= SlotW'(idx);
        fhandle_q <= rd_handle;
        flength_q <= rd_length;
        byte_q    <= byte_wide[LenW-1:0];
      end
    end
  end

  assign found_o          = found_q;
  assign slot_index_o     = slot_q;
  assign found_handle_o   = fhandle_q;
  assign found_length_o   = flength_q;
  assign byte_in_record_o = byte_q;
  assign ring_full_o      = full_q;

  a_full_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (wp_q == rp_q))
    else $error("full flag set while pointers differ");

  a_add_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add |=> valid_q[$past(wp_q)])
    else $error("written slot not marked valid");

  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> (step_q <= PtrW'(Depth - 1)))
    else $error("walk counter beyond ring depth");

endmodule

`default_nettype wire

// File: rtl/core/ring_log_offset_lookup_unit.sv
`default_nettype none

// Ring of 16 record slots (handle and byte length) that overwrites the oldest
// record once full. An item is transferred at a clock edge with start high
// and busy low; opcode_i selects add (0) or find (1). Each item yields
// exactly one result, shown for a single cycle with done_o high. The receiver
// cannot stall: the result must be taken in that cycle. An add goes through
// the add state to the response state. A find walks k slots (1 to 16,
// stopping at the slot that holds the offset) before its response. The walk
// reads one slot per cycle through the single read port of the slot store,
// oldest record first, with a saturating 24-bit running sum. busy falls right
// after the strobe, so no new item is transferred before its predecessor's
// result has been shown. ring_full_o reports the full flag after the item.
// After reset every slot reads as zero length.

module ring_log_offset_lookup_unit
  import rlol_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command side
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               opcode_i,
  input  wire logic [HandleW-1:0] record_handle_i,
  input  wire logic [LenW-1:0]    record_length_i,
  input  wire logic [OffW-1:0]    char_offset_i,
  // result side
  output logic                    done_o,
  output logic                    found_o,
  output logic [SlotW-1:0]        slot_index_o,
  output logic [HandleW-1:0]      found_handle_o,
  output logic [LenW-1:0]         found_length_o,
  output logic [LenW-1:0]         byte_in_record_o,
  output logic                    ring_full_o
);

  // command and status between controller and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  rlol_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // slot store, pointers, walk adder and result registers
  rlol_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .record_handle_i  (record_handle_i),
    .record_length_i  (record_length_i),
    .char_offset_i    (char_offset_i),
    .sts_o            (sts),
    .found_o          (found_o),
    .slot_index_o     (slot_index_o),
    .found_handle_o   (found_handle_o),
    .found_length_o   (found_length_o),
    .byte_in_record_o (byte_in_record_o),
    .ring_full_o      (ring_full_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rlol_pkg::*;

  // one expected result of the lookup unit
  typedef struct packed {
    logic               found;
    logic [SlotW-1:0]   slot;
    logic [HandleW-1:0] handle;
    logic [LenW-1:0]    length;
    logic [LenW-1:0]    byte_off;
    logic               full;
  } lookup_result_t;

  localparam int unsigned OffsetTop  = 24'hFFFFFF;
  localparam int unsigned MaxGap     = 20;
  localparam int unsigned DrainSlack = 24;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               opcode_i;
  logic [HandleW-1:0] record_handle_i;
  logic [LenW-1:0]    record_length_i;
  logic [OffW-1:0]    char_offset_i;
  logic               done_o;
  logic               found_o;
  logic [SlotW-1:0]   slot_index_o;
  logic [HandleW-1:0] found_handle_o;
  logic [LenW-1:0]    found_length_o;
  logic [LenW-1:0]    byte_in_record_o;
  logic               ring_full_o;

  ring_log_offset_lookup_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .record_handle_i (record_handle_i),
    .record_length_i (record_length_i),
    .char_offset_i   (char_offset_i),
    .done_o          (done_o),
    .found_o         (found_o),
    .slot_index_o    (slot_index_o),
    .found_handle_o  (found_handle_o),
    .found_length_o  (found_length_o),
    .byte_in_record_o(byte_in_record_o),
    .ring_full_o     (ring_full_o)
  );

  // shadow copy of the ring
  logic [HandleW-1:0] ring_handle [Depth];
  logic [LenW-1:0]    ring_length [Depth];
  int unsigned        wr_ptr;
  int unsigned        rd_ptr;
  logic               ring_full;

  lookup_result_t pending_results[$];
  lookup_result_t head_result;

  int unsigned fail_count;
  int unsigned adds_sent;
  int unsigned finds_sent;
  int unsigned hits_seen;
  int unsigned misses_seen;
  int unsigned full_results;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case the unit hangs
  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  // bytes held by the oldest k slots, saturated at the offset range
  function automatic int unsigned stored_prefix(int unsigned k);
    int unsigned acc;
    int unsigned i;
    acc = 0;
    for (i = 0; i < k && i < Depth; i++) begin
      acc = acc + ring_length[(rd_ptr + i) % Depth];
      if (acc > OffsetTop) acc = OffsetTop;
    end
    return acc;
  endfunction

  // applies one item to the shadow ring and returns the result it must give
  function automatic lookup_result_t predict_item(logic op, logic [HandleW-1:0] h,
                                                  logic [LenW-1:0] l, logic [OffW-1:0] o);
    lookup_result_t r;
    int unsigned run_sum;
    int unsigned prev_sum;
    int unsigned s;
    int unsigned i;
    logic located;
    r = '0;
    if (op == OpAdd) begin
      ring_handle[wr_ptr] = h;
      ring_length[wr_ptr] = l;
      wr_ptr = (wr_ptr + 1) % Depth;
      // a full ring loses its oldest record
      if (ring_full) rd_ptr = (rd_ptr + 1) % Depth;
      ring_full = (wr_ptr == rd_ptr);
    end else begin
      run_sum = 0;
      located = 1'b0;
      for (i = 0; i < Depth && !located; i++) begin
        s = (rd_ptr + i) % Depth;
        prev_sum = run_sum;
        run_sum = run_sum + ring_length[s];
        if (run_sum > OffsetTop) run_sum = OffsetTop;
        if (run_sum > o) begin
          located    = 1'b1;
          r.found    = 1'b1;
          r.slot     = SlotW'(s);
          r.handle   = ring_handle[s];
          r.length   = ring_length[s];
          r.byte_off = LenW'(o - prev_sum);
        end
      end
    end
    r.full = ring_full;
    return r;
  endfunction

  task automatic check_field(string name, logic [HandleW-1:0] exp_v, logic [HandleW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // every strobe is compared with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no transfer outstanding");
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("found", HandleW'(head_result.found), HandleW'(found_o));
        check_field("slot_index", HandleW'(head_result.slot), HandleW'(slot_index_o));
        check_field("found_handle", head_result.handle, found_handle_o);
        check_field("found_length", HandleW'(head_result.length),
                    HandleW'(found_length_o));
        check_field("byte_in_record", HandleW'(head_result.byte_off),
                    HandleW'(byte_in_record_o));
        check_field("ring_full", HandleW'(head_result.full), HandleW'(ring_full_o));
        if (head_result.found) hits_seen++;
        if (head_result.full) full_results++;
      end
    end
  end

  // drives one item and waits for its transfer; start is left high so a
  // following item can go out back to back
  task automatic send_item(logic op, logic [HandleW-1:0] h, logic [LenW-1:0] l,
                           logic [OffW-1:0] o);
    @(negedge clk_i);
    start           <= 1'b1;
    opcode_i        <= op;
    record_handle_i <= h;
    record_length_i <= l;
    char_offset_i   <= o;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(predict_item(op, h, l, o));
    if (op == OpAdd) adds_sent++;
    else begin
      finds_sent++;
      if (!pending_results[$].found) misses_seen++;
    end
  endtask

  task automatic pause_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [LenW-1:0] pick_length();
    case ($urandom_range(7))
      0:       return '0;
      1, 2:    return LenW'($urandom_range(1, 15));
      3:       return '1;
      default: return LenW'($urandom);
    endcase
  endfunction

  function automatic logic [HandleW-1:0] pick_handle();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // offsets mostly land inside the stored data, some on record edges,
  // the rest anywhere in the range
  function automatic logic [OffW-1:0] pick_offset();
    int unsigned total;
    total = stored_prefix(Depth);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return OffW'($urandom_range(0, total));
      6:                return OffW'(stored_prefix($urandom_range(0, Depth)));
      7:                return OffW'(OffsetTop);
      default:          return OffW'($urandom);
    endcase
  endfunction

  // finds on a freshly cleared ring never locate anything
  task automatic test_empty_ring();
    send_item(OpFind, '1, '1, '0);
    send_item(OpFind, '0, '0, OffW'(OffsetTop));
  endtask

  // fills every slot with edge-value records, then overwrites the oldest
  task automatic test_fill_and_overwrite();
    int unsigned i;
    logic [LenW-1:0] l;
    logic [HandleW-1:0] h;
    for (i = 0; i < Depth; i++) begin
      case (i)
        0:       begin l = '0;  h = '0; end
        1:       begin l = '1;  h = '1; end
        2:       begin l = LenW'(1); h = 32'h5555_5555; end
        3:       begin l = '0;  h = 32'hAAAA_AAAA; end
        default: begin l = LenW'(i * 3); h = HandleW'(i * 32'h0101_0101); end
      endcase
      send_item(OpAdd, h, l, '1);
    end
    // full now: these push the read pointer along
    send_item(OpAdd, 32'hDEAD_0001, 20'h0_0007, '0);
    send_item(OpAdd, 32'hDEAD_0002, '0, '1);
  endtask

  task automatic test_find_edges();
    int unsigned total;
    total = stored_prefix(Depth);
    send_item(OpFind, '0, '0, '0);
    send_item(OpFind, '0, '0, OffW'(total - 1));
    send_item(OpFind, '0, '0, OffW'(total));
    send_item(OpFind, '1, '1, OffW'(OffsetTop));
    send_item(OpFind, '0, '0, OffW'(stored_prefix(2)));
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned idle_pct);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < idle_pct) pause_sender($urandom_range(1, MaxGap));
      if ($urandom_range(1)) send_item(OpFind, pick_handle(), pick_length(), pick_offset());
      else send_item(OpAdd, pick_handle(), pick_length(), pick_offset());
    end
    // sender holds off until the unit has answered everything
    wait_for_results();
  endtask

  initial begin
    fail_count      = 0;
    adds_sent       = 0;
    finds_sent      = 0;
    hits_seen       = 0;
    misses_seen     = 0;
    full_results    = 0;
    wr_ptr          = 0;
    rd_ptr          = 0;
    ring_full       = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      ring_handle[i] = '0;
      ring_length[i] = '0;
    end
    rst_ni          = 1'b0;
    start           = 1'b0;
    opcode_i        = OpAdd;
    record_handle_i = '0;
    record_length_i = '0;
    char_offset_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_ring();
    test_fill_and_overwrite();
    test_find_edges();
    wait_for_results();
    test_random_traffic(310, 12);
    test_random_traffic(310, 64);
    test_random_traffic(310, 0);

    repeat (DrainSlack) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    $display("covered %0d adds and %0d finds, %0d located and %0d past the stored data",
             adds_sent, finds_sent, hits_seen, misses_seen);
    $display("%0d results reported a full ring", full_results);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/rlol_pkg.sv
rtl/core/rlol_ctrl.sv
rtl/core/rlol_datapath.sv
rtl/core/ring_log_offset_lookup_unit.sv
tb/sv/tb_top.sv
